FILE: hdl/rau_pkg.sv
`default_nettype none
package rau_pkg;
  typedef enum logic [2:0] {
    CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
    CMD_NEG = 3'd4, CMD_INV = 3'd5, CMD_ABS = 3'd6, CMD_PASS = 3'd7
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_COMBINE, ST_GCD_START, ST_GCD_WAIT,
    ST_Q0_START, ST_Q0_WAIT, ST_Q1_START, ST_Q1_WAIT, ST_DONE
  } state_t;
endpackage
`default_nettype wire

FILE: hdl/rau_if.sv
`default_nettype none
interface rau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [31:0] b_den;
  modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] r_num;
  logic [31:0] r_den;
  logic        zero_gcd;
  modport source (output valid, r_num, r_den, zero_gcd, input ready);
  modport sink (input valid, r_num, r_den, zero_gcd, output ready);
endinterface
`default_nettype wire

FILE: hdl/rau_divider.sv
`default_nettype none
// Restoring signed divider, one quotient bit per cycle. Truncating
// quotient and remainder, wrapped at W bits. Divisor must be nonzero.
module rau_divider #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rem
);
  localparam int CW = $clog2(W + 1);

  logic          busy;
  logic [W-1:0]  q_reg;
  logic [W-1:0]  r_reg;
  logic [W-1:0]  d_mag;
  logic          neg_q;
  logic          neg_r;
  logic [CW-1:0] count;
  logic [W:0]    trial;
  logic [W:0]    shifted;

  assign shifted = {r_reg, q_reg[W-1]};
  assign trial   = shifted - {1'b0, d_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(W);
        q_reg <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
        d_mag <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
        r_reg <= '0;
        neg_q <= dividend[W-1] ^ divisor[W-1];
        neg_r <= dividend[W-1];
      end else if (busy) begin
        if (!trial[W]) begin
          r_reg <= trial[W-1:0];
          q_reg <= {q_reg[W-2:0], 1'b1};
        end else begin
          r_reg <= shifted[W-1:0];
          q_reg <= {q_reg[W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = neg_q ? (~q_reg + 1'b1) : q_reg;
  assign rem  = neg_r ? (~r_reg + 1'b1) : r_reg;
endmodule
`default_nettype wire

FILE: hdl/rational_arithmetic_unit.sv
`default_nettype none
// Binary ops use multiply states MUL0, MUL1 and (add, sub) MUL2, then gcd
// rounds and quotient divisions in the shared serial divider. Unary ops go
// straight to the done state. One transaction at a time; with no output
// stall, the divider's one quotient bit per cycle sets the binary-op rate.
// Reset: synchronous active-high rst clears the sequencer and output valid.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  rau_in_if.sink   in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;
  localparam int W = WORD_BITS;

  state_t state, state_next;
  logic [W-1:0] an, ad, bn, bd;
  cmd_t         cmd_reg;
  logic [W-1:0] p0, p1, p2;
  logic [W-1:0] n_reg, d_reg, x_reg, y_reg;
  logic [W-1:0] r_num_reg, r_den_reg;
  logic         zf_reg, out_valid;
  logic [W-1:0] m_a, m_b, m_p;
  logic [W-1:0] dv_a, dv_b, dv_q, dv_r;
  logic         div_start;
  logic         div_done;

  function automatic logic [W-1:0] sx(input logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[W-1:0];
  endfunction

  function automatic logic [31:0] to32(input logic [W-1:0] v);
    logic [63:0] e;
    e = {{(64-W){v[W-1]}}, v};
    return e[31:0];
  endfunction

  // one shared multiplier, wrapped product
  always_comb begin
    m_a = an;
    m_b = bd;
    case (state)
      ST_MUL0: begin m_a = (cmd_reg == CMD_MUL) ? an : an;
                     m_b = (cmd_reg == CMD_MUL) ? bn : bd; end
      ST_MUL1: begin m_a = ad; m_b = (cmd_reg == CMD_DIV) ? bn : bd; end
      ST_MUL2: begin m_a = bn; m_b = ad; end
      default: begin m_a = an; m_b = bd; end
    endcase
  end
  assign m_p = W'(m_a * m_b);

  assign in_ch.ready = (state == ST_IDLE) && !out_valid;

  always_comb begin
    div_start = (state == ST_GCD_START) || (state == ST_Q0_START) ||
                (state == ST_Q1_START);
    dv_a = x_reg;
    dv_b = y_reg;
    case (state)
      ST_Q0_START: begin dv_a = n_reg; dv_b = x_reg; end
      ST_Q1_START: begin dv_a = d_reg; dv_b = x_reg; end
      default: begin dv_a = x_reg; dv_b = y_reg; end
    endcase
  end

  rau_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dv_a), .divisor(dv_b),
    .done(div_done), .quot(dv_q), .rem(dv_r)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_ch.valid && in_ch.ready) begin
        state_next = (in_ch.cmd <= 3'(CMD_DIV)) ? ST_MUL0 : ST_DONE;
      end
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) ? ST_MUL2
                                                                       : ST_COMBINE;
      ST_MUL2: state_next = ST_COMBINE;
      ST_COMBINE: state_next = ST_GCD_START;
      ST_GCD_START: state_next = (y_reg == '0) ? ST_Q0_START : ST_GCD_WAIT;
      ST_GCD_WAIT: if (div_done) state_next = ST_GCD_START;
      ST_Q0_START: state_next = (x_reg == '0) ? ST_DONE : ST_Q0_WAIT;
      ST_Q0_WAIT: if (div_done) state_next = ST_Q1_START;
      ST_Q1_START: state_next = ST_Q1_WAIT;
      ST_Q1_WAIT: if (div_done) state_next = ST_DONE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_ch.valid && in_ch.ready) begin
          cmd_reg <= cmd_t'(in_ch.cmd);
          an <= sx(in_ch.a_num);
          ad <= sx(in_ch.a_den);
          bn <= sx(in_ch.b_num);
          bd <= sx(in_ch.b_den);
          zf_reg <= 1'b0;
        end
        ST_MUL0: p0 <= m_p;
        ST_MUL1: p1 <= m_p;
        ST_MUL2: p2 <= m_p;
        ST_COMBINE: begin
          case (cmd_reg)
            CMD_ADD: n_reg <= p0 + p2;
            CMD_SUB: n_reg <= p0 - p2;
            default: n_reg <= p0;
          endcase
          d_reg <= p1;
          x_reg <= (cmd_reg == CMD_ADD) ? p0 + p2 :
                   (cmd_reg == CMD_SUB) ? p0 - p2 : p0;
          y_reg <= p1;
        end
        ST_GCD_WAIT: if (div_done) begin
          x_reg <= y_reg;
          y_reg <= dv_r;
        end
        ST_Q0_START: if (x_reg == '0) begin
          n_reg  <= '0;
          d_reg  <= '0;
          zf_reg <= 1'b1;
        end
        ST_Q0_WAIT: if (div_done) n_reg <= dv_q;
        ST_Q1_WAIT: if (div_done) d_reg <= dv_q;
        ST_DONE: begin
          out_valid <= 1'b1;
          case (cmd_reg)
            CMD_NEG: begin r_num_reg <= W'(~an + 1'b1); r_den_reg <= ad; end
            CMD_INV: begin r_num_reg <= ad; r_den_reg <= an; end
            CMD_ABS: begin
              r_num_reg <= an[W-1] ? W'(~an + 1'b1) : an;
              r_den_reg <= ad[W-1] ? W'(~ad + 1'b1) : ad;
            end
            CMD_PASS: begin r_num_reg <= an; r_den_reg <= ad; end
            default: begin r_num_reg <= n_reg; r_den_reg <= d_reg; end
          endcase
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.r_num    = to32(r_num_reg);
  assign out_ch.r_den    = to32(r_den_reg);
  assign out_ch.zero_gcd = zf_reg;
endmodule
`default_nettype wire

FILE: hdl/rau_checker.sv
`default_nettype none
module rau_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [31:0] r_num,
  input wire logic zero_gcd
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input accepted with result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(r_num))
    else $error("result dropped");
  a_zero_num: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_gcd |-> r_num == 32'd0) else $error("zero gcd num");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind rational_arithmetic_unit rau_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .r_num(out_ch.r_num),
  .zero_gcd(out_ch.zero_gcd)
);
`default_nettype wire

FILE: tb/rational_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] a_num;
    logic [31:0] a_den;
    logic [31:0] b_num;
    logic [31:0] b_den;
  } op_item_t;

  typedef struct packed {
    logic [31:0] r_num;
    logic [31:0] r_den;
    logic        zero_gcd;
  } ratio_t;

  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rau_in_if  in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  op_item_t pending_ops[$];
  ratio_t   expected_ratios[$];
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       error_count = 0;
  int       ratio_count = 0;
  int       zero_gcd_count = 0;
  int       idle_cycles = 0;
  bit       stim_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Truncating remainder and quotient on 32-bit signed words.
  function automatic logic signed [31:0] trunc_rem(logic signed [31:0] x,
                                                   logic signed [31:0] y);
    logic [31:0] mx, my, r;
    mx = x[31] ? -x : x;
    my = y[31] ? -y : y;
    r = mx % my;
    return x[31] ? -r : r;
  endfunction

  function automatic logic signed [31:0] trunc_quot(logic signed [31:0] x,
                                                    logic signed [31:0] y);
    logic [31:0] mx, my, q;
    mx = x[31] ? -x : x;
    my = y[31] ? -y : y;
    q = mx / my;
    return (x[31] != y[31]) ? -q : q;
  endfunction

  function automatic ratio_t predict_ratio(op_item_t it);
    logic signed [31:0] an, ad, bn, bd, n, d, x, y, t;
    ratio_t res;
    an = it.a_num; ad = it.a_den; bn = it.b_num; bd = it.b_den;
    n = an; d = ad;
    res.zero_gcd = 1'b0;
    case (it.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        case (it.cmd)
          CMD_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
          CMD_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
          CMD_MUL: begin n = an * bn; d = ad * bd; end
          default: begin n = an * bd; d = ad * bn; end
        endcase
        x = n; y = d;
        while (y != 0) begin
          t = trunc_rem(x, y);
          x = y;
          y = t;
        end
        if (x == 0) begin
          n = 0; d = 0;
          res.zero_gcd = 1'b1;
        end else begin
          n = trunc_quot(n, x);
          d = trunc_quot(d, x);
        end
      end
      CMD_NEG: n = -an;
      CMD_INV: begin n = ad; d = an; end
      CMD_ABS: begin n = an[31] ? -an : an; d = ad[31] ? -ad : ad; end
      default: ;
    endcase
    res.r_num = n;
    res.r_den = d;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, ratio_count);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4, 5: return $urandom;
      default: return $signed($urandom_range(0, 80)) - 40;
    endcase
  endfunction

  task automatic push_op(cmd_t c, logic [31:0] an, logic [31:0] ad,
                         logic [31:0] bn, logic [31:0] bd);
    op_item_t it;
    it.cmd = c; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
    pending_ops.push_back(it);
  endtask

  // Driver: hold valid until accepted, idle at random between transactions.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.cmd <= CMD_ADD;
      in_ch.a_num <= '0;
      in_ch.a_den <= '0;
      in_ch.b_num <= '0;
      in_ch.b_den <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_ratios.push_back(predict_ratio({cmd_t'(in_ch.cmd), in_ch.a_num,
            in_ch.a_den, in_ch.b_num, in_ch.b_den}));
      end
      if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        op_item_t it;
        it = pending_ops.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= it.cmd;
        in_ch.a_num <= it.a_num;
        in_ch.a_den <= it.a_den;
        in_ch.b_num <= it.b_num;
        in_ch.b_den <= it.b_den;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      idle_cycles <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        ratio_count++;
        if (expected_ratios.size() == 0) begin
          report_mismatch("unexpected result", out_ch.r_num, 32'd0);
        end else begin
          ratio_t want;
          want = expected_ratios.pop_front();
          if (out_ch.zero_gcd) zero_gcd_count++;
          if (out_ch.r_num !== want.r_num) report_mismatch("r_num", out_ch.r_num, want.r_num);
          if (out_ch.r_den !== want.r_den) report_mismatch("r_den", out_ch.r_den, want.r_den);
          if (out_ch.zero_gcd !== want.zero_gcd)
            report_mismatch("zero_gcd", out_ch.zero_gcd, want.zero_gcd);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: every operation, extremes, zero gcd, most negative value.
    push_op(CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    push_op(CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    push_op(CMD_MUL, -32'sd3, 32'd4, 32'd2, -32'sd6);
    push_op(CMD_DIV, 32'd5, 32'd7, 32'd10, 32'd14);
    push_op(CMD_ADD, 32'd0, 32'd0, 32'd0, 32'd0);
    push_op(CMD_MUL, 32'd0, 32'd0, 32'd5, 32'd5);
    push_op(CMD_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
    push_op(CMD_MUL, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
    push_op(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    push_op(CMD_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    push_op(CMD_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    push_op(CMD_NEG, 32'h8000_0000, 32'd3, 32'hffff_ffff, 32'hffff_ffff);
    push_op(CMD_NEG, 32'd7, 32'hffff_ffff, 32'd0, 32'd0);
    push_op(CMD_INV, 32'd0, 32'h7fff_ffff, 32'd1, 32'd1);
    push_op(CMD_ABS, 32'h8000_0000, 32'hffff_fff0, 32'd0, 32'd0);
    push_op(CMD_ABS, 32'h7fff_ffff, 32'd0, 32'hffff_ffff, 32'hffff_ffff);
    push_op(CMD_PASS, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff, 32'hffff_ffff);
    push_op(CMD_PASS, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int i = 0; i < 275; i++)
        push_op(cmd_t'($urandom_range(0, 7)), rand_word(), rand_word(),
                rand_word(), rand_word());
      while (pending_ops.size() > 0) @(posedge clk);
    end
    stim_done = 1'b1;
  end

  // Watchdog and end of run.
  initial begin
    int tail;
    tail = 0;
    @(negedge rst);
    while (!(stim_done && !in_ch.valid && expected_ratios.size() == 0
             && tail >= TAIL_CYCLES)) begin
      @(posedge clk);
      if (stim_done && !in_ch.valid && expected_ratios.size() == 0) tail++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", expected_ratios.size());
        $display("rational_arithmetic_unit test failed");
        $finish;
      end
    end
    $display("checked %0d results over four handshake pressure phases", ratio_count);
    $display("%0d results reported a zero gcd, %0d mismatches", zero_gcd_count, error_count);
    if (error_count == 0)
      $display("rational_arithmetic_unit test passed");
    else
      $display("rational_arithmetic_unit test failed");
    $finish;
  end
endmodule
